// ----- src/svfs_pkg.sv -----
// Shared types, constants and the control store of the state variable filter.
// Used by the datapath and by the top level; no dependencies.
package svfs_pkg;

   // field widths and fixed-point positions
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int COEF_FRAC   = 15;
   localparam int QGAIN_FRAC  = 14;
   localparam int HP_BITS     = SAMPLE_BITS + 8;
   localparam int MUL_B_BITS  = COEF_BITS + 1;
   localparam int PROD_BITS   = HP_BITS + MUL_B_BITS;
   localparam int REQ_BITS    = SAMPLE_BITS + 2 * COEF_BITS;
   localparam int REQ_BYTES   = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS    = HP_BITS + 2 * SAMPLE_BITS;
   localparam int RSP_BYTES   = (RSP_BITS + 7) / 8;

   // step counter codes
   localparam int STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] ST_WAIT   = 3'd0;
   localparam logic [STEP_BITS-1:0] ST_DIFF   = 3'd1;
   localparam logic [STEP_BITS-1:0] ST_HIGH   = 3'd2;
   localparam logic [STEP_BITS-1:0] ST_LOW    = 3'd3;
   localparam logic [STEP_BITS-1:0] ST_FINISH = 3'd4;

   // hold conditions: while true, the step counter stays put
   localparam logic [1:0] HC_NONE     = 2'd0;
   localparam logic [1:0] HC_NO_INPUT = 2'd1;
   localparam logic [1:0] HC_OUT_BUSY = 2'd2;

   // multiplier operand selects
   localparam logic [1:0] A_DIFF = 2'd0;
   localparam logic [1:0] A_BAND = 2'd1;
   localparam logic [1:0] A_HIGH = 2'd2;
   localparam logic       B_Q    = 1'b0;
   localparam logic       B_FC   = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [HP_BITS-1:0]     wide_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   // one control word of the microprogram
   typedef struct packed {
      logic                 in_ready;
      logic [1:0]           hold_cond;
      logic [1:0]           a_sel;
      logic                 b_sel;
      logic                 ld_prod;
      logic                 ld_hp;
      logic                 ld_lp;
      logic                 finish;
      logic [STEP_BITS-1:0] next_step;
   } ucode_type;

   // strobes from the sequencer to the datapath
   typedef struct packed {
      logic       ld_in;
      logic [1:0] a_sel;
      logic       b_sel;
      logic       ld_prod;
      logic       ld_hp;
      logic       ld_lp;
      logic       finish;
   } ctrl_type;

   // control store
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type w;
      w = '0;
      case (step)
         ST_WAIT: begin
            w.in_ready  = 1'b1;
            w.hold_cond = HC_NO_INPUT;
            w.next_step = ST_DIFF;
         end
         ST_DIFF: begin   // prod = q * (x - band)
            w.a_sel     = A_DIFF;
            w.b_sel     = B_Q;
            w.ld_prod   = 1'b1;
            w.next_step = ST_HIGH;
         end
         ST_HIGH: begin   // high = prod >> 14 - low; prod = fc * band
            w.a_sel     = A_BAND;
            w.b_sel     = B_FC;
            w.ld_prod   = 1'b1;
            w.ld_hp     = 1'b1;
            w.next_step = ST_LOW;
         end
         ST_LOW: begin    // new low from prod; prod = fc * high
            w.a_sel     = A_HIGH;
            w.b_sel     = B_FC;
            w.ld_prod   = 1'b1;
            w.ld_lp     = 1'b1;
            w.next_step = ST_FINISH;
         end
         ST_FINISH: begin // new band, commit state, load result
            w.hold_cond = HC_OUT_BUSY;
            w.finish    = 1'b1;
            w.next_step = ST_WAIT;
         end
         default: begin
            w.next_step = ST_WAIT;
         end
      endcase
      return w;
   endfunction

   // clamp a wide value to the sample range
   function automatic sample_type sat_sample(input wide_type x);
      sample_type r;
      r = x[SAMPLE_BITS-1:0];
      if (!x[HP_BITS-1] && (|x[HP_BITS-2:SAMPLE_BITS-1])) begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (x[HP_BITS-1] && !(&x[HP_BITS-2:SAMPLE_BITS-1])) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
      return r;
   endfunction

endpackage

// ----- src/state_variable_filter_sat_unit.sv -----
// Top level of the saturating two-pole state variable filter: microcode
// sequencer, result handshake. Depends on svfs_pkg and svfs_datapath.
//
// channel | dir | data                                     | user
// req_    | in  | sample_in, cutoff_coef, q_gain (48 bits) | none
// rsp_    | out | highpass_out, bandpass_out, lowpass_out  | none
//
// Each item runs through an accept step and four microcode steps, three of
// which share the single 24x17 multiplier (one product per step).
// Reset clears the step counter, the result valid flag and both integrators.
// A waiting result does not block the next accept; the final step holds only
// while the previous result is still untaken.
module state_variable_filter_sat_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] sample_in, [31:16] cutoff_coef, [47:32] q_gain
   input  logic [svfs_pkg::REQ_BYTES*8-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [23:0] highpass_out, [39:24] bandpass_out, [55:40] lowpass_out
   output logic [svfs_pkg::RSP_BYTES*8-1:0]    rsp_tdata
);
   import svfs_pkg::*;

   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   logic                 rsp_tvalid_ff;
   logic                 rsp_tvalid_in;
   ucode_type            cw;
   ctrl_type             ctrl;
   logic                 hold;

   // decode the current control word
   always_comb begin
      cw   = ucode_rom(step_ff);
      hold = ((cw.hold_cond == HC_NO_INPUT) && !req_tvalid) ||
             ((cw.hold_cond == HC_OUT_BUSY) && rsp_tvalid_ff && !rsp_tready);
      step_in      = hold ? step_ff : cw.next_step;
      ctrl.ld_in   = cw.in_ready & req_tvalid;
      ctrl.a_sel   = cw.a_sel;
      ctrl.b_sel   = cw.b_sel;
      ctrl.ld_prod = cw.ld_prod;
      ctrl.ld_hp   = cw.ld_hp;
      ctrl.ld_lp   = cw.ld_lp;
      ctrl.finish  = cw.finish & ~hold;
      if (ctrl.finish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   // advance the step counter and the result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ST_WAIT;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   svfs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

   assign req_tready = cw.in_ready;
   assign rsp_tvalid = rsp_tvalid_ff;

   // an accepted transaction starts the microprogram on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (step_ff == ST_DIFF))
      else $error("accepted transaction did not start the program");

   // a new result appears only right after the final step
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(step_ff) == ST_FINISH))
      else $error("result raised outside the final step");

   // the final step waits while the previous result is untaken
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_FINISH && rsp_tvalid_ff && !rsp_tready)
      |=> (step_ff == ST_FINISH))
      else $error("final step overwrote a pending result");

endmodule

// ----- src/svfs_datapath.sv -----
// Datapath of the state variable filter: operand registers, one shared
// multiplier, integrator state and the result register. Depends on svfs_pkg.
module svfs_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  svfs_pkg::ctrl_type                     ctrl,
   input  logic [svfs_pkg::REQ_BYTES*8-1:0]       req_data,
   output logic [svfs_pkg::RSP_BYTES*8-1:0]       rsp_data
);
   import svfs_pkg::*;

   sample_type             x_ff;
   logic [COEF_BITS-1:0]   fc_ff;
   logic [COEF_BITS-1:0]   q_ff;
   sample_type             band_ff;
   sample_type             low_ff;
   prod_type               prod_ff;
   prod_type               prod_in;
   wide_type               hp_ff;
   wide_type               hp_in;
   sample_type             lp_new_ff;
   sample_type             lp_new_in;
   sample_type             bp_new_in;
   logic [RSP_BYTES*8-1:0] rsp_ff;
   logic [RSP_BYTES*8-1:0] rsp_in;

   logic signed [SAMPLE_BITS:0] diff;
   wide_type                    mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   prod_type                    prod_shq;
   prod_type                    prod_shc;
   wide_type                    low_ext;
   wide_type                    band_ext;
   wide_type                    lp_sum;
   wide_type                    bp_sum;

   // select multiplier operands
   always_comb begin
      diff = {x_ff[SAMPLE_BITS-1], x_ff} - {band_ff[SAMPLE_BITS-1], band_ff};
      case (ctrl.a_sel)
         A_DIFF:  mul_a = {{(HP_BITS-SAMPLE_BITS-1){diff[SAMPLE_BITS]}}, diff};
         A_BAND:  mul_a = band_ext;
         A_HIGH:  mul_a = hp_ff;
         default: mul_a = '0;
      endcase
      mul_b = (ctrl.b_sel == B_FC) ? {1'b0, fc_ff} : {1'b0, q_ff};
      prod_in = mul_a * mul_b;
   end

   // scale products, integrate, clamp
   always_comb begin
      low_ext   = {{(HP_BITS-SAMPLE_BITS){low_ff[SAMPLE_BITS-1]}}, low_ff};
      band_ext  = {{(HP_BITS-SAMPLE_BITS){band_ff[SAMPLE_BITS-1]}}, band_ff};
      prod_shq  = prod_ff >>> QGAIN_FRAC;
      prod_shc  = prod_ff >>> COEF_FRAC;
      hp_in     = prod_shq[HP_BITS-1:0] - low_ext;
      lp_sum    = low_ext + prod_shc[HP_BITS-1:0];
      bp_sum    = band_ext + prod_shc[HP_BITS-1:0];
      lp_new_in = sat_sample(lp_sum);
      bp_new_in = sat_sample(bp_sum);
      rsp_in    = '0;
      rsp_in[RSP_BITS-1:0] = {lp_new_ff, bp_new_in, hp_ff};
   end

   // latch the incoming transaction
   always_ff @(posedge clock) begin
      if (ctrl.ld_in) begin
         x_ff  <= req_data[SAMPLE_BITS-1:0];
         fc_ff <= req_data[SAMPLE_BITS+COEF_BITS-1:SAMPLE_BITS];
         q_ff  <= req_data[REQ_BITS-1:SAMPLE_BITS+COEF_BITS];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctrl.ld_prod) begin
         prod_ff <= prod_in;
      end
      if (ctrl.ld_hp) begin
         hp_ff <= hp_in;
      end
      if (ctrl.ld_lp) begin
         lp_new_ff <= lp_new_in;
      end
      if (ctrl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         low_ff  <= '0;
      end else if (ctrl.finish) begin
         band_ff <= bp_new_in;
         low_ff  <= lp_new_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
